// File: rtl/tef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tef_pkg
// Beat types, symbol codes and the static extension type table shared by the
// extension fingerprinter modules.
// ----------------------------------------------------------------------------
package tef_pkg;

	// symbol kinds
	localparam logic [1:0] KIND_OPEN    = 2'd0;
	localparam logic [1:0] KIND_CLOSE   = 2'd1;
	localparam logic [1:0] KIND_HEX     = 2'd2;
	localparam logic [1:0] KIND_DISCARD = 2'd3;

	// most results one input beat can cause
	localparam int MAX_SYMS = 5;
	localparam int CNT_W    = $clog2(MAX_SYMS + 1);
	localparam int IDX_W    = $clog2(MAX_SYMS);

	// all GREASE types print as this
	localparam logic [15:0] GREASE_OUT = 16'h0a0a;

	localparam int NUM_STATIC = 34;
	localparam logic [15:0] STATIC_TYPES [NUM_STATIC] = '{
		16'd1, 16'd5, 16'd7, 16'd8, 16'd9, 16'd10, 16'd11, 16'd13, 16'd15,
		16'd16, 16'd17, 16'd24, 16'd27, 16'd28, 16'd43, 16'd45, 16'd50,
		16'd2570, 16'd6682, 16'd10794, 16'd14906, 16'd19018, 16'd21760,
		16'd23130, 16'd27242, 16'd31354, 16'd35466, 16'd39578, 16'd43690,
		16'd47802, 16'd51914, 16'd56026, 16'd60138, 16'd64250
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       vector_end;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] symbol_kind;
		logic [3:0] hex_digit;
		logic       run_last;
	} out_beat_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] digit;
	} sym_t;

	// symbols caused by one input beat, slot 0 goes out first
	typedef struct packed {
		logic [CNT_W-1:0]        count;
		sym_t [MAX_SYMS-1:0]     syms;
	} sym_group_t;

	function automatic logic is_static_type(input logic [15:0] t);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_STATIC; i++) begin
			if (STATIC_TYPES[i] == t) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// File: rtl/tef_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tef_parser
// Extension vector parser: per accepted beat, updates the parse state and
// builds the group of symbols that beat causes.
// ----------------------------------------------------------------------------
module tef_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  tef_pkg::in_beat_t   beat,
	output tef_pkg::sym_group_t group
);

	localparam logic [2:0] PH_TYPE_HI = 3'd0;
	localparam logic [2:0] PH_TYPE_LO = 3'd1;
	localparam logic [2:0] PH_LEN_HI  = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_VALUE   = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  type_hi_q, type_hi_d;
	logic [15:0] left_q, left_d;
	logic        static_q, static_d;

	logic [7:0]  b;
	logic        last;
	logic [15:0] raw_type;
	logic [15:0] shown;
	logic        done;

	assign b        = beat.data_byte;
	assign last     = beat.vector_end;
	assign raw_type = {type_hi_q, b};
	assign shown    = (type_hi_q == b && b[3:0] == 4'ha) ? tef_pkg::GREASE_OUT : raw_type;

	always_comb begin
		phase_d   = phase_q;
		type_hi_d = type_hi_q;
		left_d    = left_q;
		static_d  = static_q;
		done      = 1'b0;
		group     = '0;
		unique case (phase_q)
			PH_TYPE_LO: begin
				if (!last) begin
					static_d = tef_pkg::is_static_type(raw_type);
					group.syms[0] = '{kind: tef_pkg::KIND_OPEN, digit: 4'h0};
					group.syms[1] = '{kind: tef_pkg::KIND_HEX, digit: shown[15:12]};
					group.syms[2] = '{kind: tef_pkg::KIND_HEX, digit: shown[11:8]};
					group.syms[3] = '{kind: tef_pkg::KIND_HEX, digit: shown[7:4]};
					group.syms[4] = '{kind: tef_pkg::KIND_HEX, digit: shown[3:0]};
					group.count   = tef_pkg::CNT_W'(5);
					phase_d       = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				left_d = {b, 8'h00};
				if (last) begin
					group.syms[0] = '{kind: tef_pkg::KIND_DISCARD, digit: 4'h0};
					group.count   = tef_pkg::CNT_W'(1);
				end else begin
					if (static_q) begin
						group.syms[0] = '{kind: tef_pkg::KIND_HEX, digit: b[7:4]};
						group.syms[1] = '{kind: tef_pkg::KIND_HEX, digit: b[3:0]};
						group.count   = tef_pkg::CNT_W'(2);
					end
					phase_d = PH_LEN_LO;
				end
			end
			PH_LEN_LO, PH_VALUE: begin
				left_d = (phase_q == PH_LEN_LO) ? {left_q[15:8], b} : left_q - 16'd1;
				if (left_d == 16'd0) begin
					// extension ends on this byte
					if (static_q) begin
						group.syms[0] = '{kind: tef_pkg::KIND_HEX, digit: b[7:4]};
						group.syms[1] = '{kind: tef_pkg::KIND_HEX, digit: b[3:0]};
						group.syms[2] = '{kind: tef_pkg::KIND_CLOSE, digit: 4'h0};
						group.count   = tef_pkg::CNT_W'(3);
					end else begin
						group.syms[0] = '{kind: tef_pkg::KIND_CLOSE, digit: 4'h0};
						group.count   = tef_pkg::CNT_W'(1);
					end
					done = 1'b1;
				end else if (last) begin
					group.syms[0] = '{kind: tef_pkg::KIND_DISCARD, digit: 4'h0};
					group.count   = tef_pkg::CNT_W'(1);
				end else begin
					if (static_q) begin
						group.syms[0] = '{kind: tef_pkg::KIND_HEX, digit: b[7:4]};
						group.syms[1] = '{kind: tef_pkg::KIND_HEX, digit: b[3:0]};
						group.count   = tef_pkg::CNT_W'(2);
					end
					phase_d = PH_VALUE;
				end
			end
			default: begin
				// type high byte, and unused phase codes
				type_hi_d = b;
				phase_d   = PH_TYPE_LO;
			end
		endcase
		if (done) begin
			phase_d  = PH_TYPE_HI;
			left_d   = 16'd0;
			static_d = 1'b0;
		end
		if (last) begin
			phase_d   = PH_TYPE_HI;
			type_hi_d = 8'h00;
			left_d    = 16'd0;
			static_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TYPE_HI;
			type_hi_q <= 8'h00;
			left_q    <= 16'd0;
			static_q  <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_d;
			type_hi_q <= type_hi_d;
			left_q    <= left_d;
			static_q  <= static_d;
		end
	end

endmodule

// File: rtl/tef_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tef_emitter
// Holds one beat's symbol group and sends it out one symbol per cycle, while out_ready
// lets it, through an output register; flags the last symbol of each group.
// ----------------------------------------------------------------------------
module tef_emitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  tef_pkg::sym_group_t  group,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tef_pkg::out_beat_t   out_data
);

	logic                        grp_valid_q;
	tef_pkg::sym_group_t         grp_q;
	logic [tef_pkg::IDX_W-1:0]   idx_q;
	logic                        out_valid_q;
	tef_pkg::out_beat_t          out_q;

	logic adv;
	logic last_sym;

	assign adv      = grp_valid_q && (!out_valid_q || out_ready);
	assign last_sym = (tef_pkg::CNT_W'(idx_q) + tef_pkg::CNT_W'(1)) == grp_q.count;
	assign free     = !grp_valid_q || (adv && last_sym);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// empty groups never enter; the caller must load only when the group is free (not enforced here)
			if (load && group.count != '0) begin
				grp_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (adv) begin
				if (last_sym) begin
					grp_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + tef_pkg::IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.symbol_kind <= grp_q.syms[idx_q].kind;
			out_q.hex_digit   <= grp_q.syms[idx_q].digit;
			out_q.run_last    <= last_sym;
		end
		if (load) begin
			grp_q <= group;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/tls_extension_fingerprinter_unit.sv
`timescale 1ns / 1ps
// A beat's group is registered in the group register at its accept edge; its first symbol then moves to the output
// register (out_data) once that register is empty or being taken. Output runs one symbol per cycle while out_ready
// holds; a byte causes 0 to 5 symbols, and a new byte is taken only once the last symbol of the group before moves out.
// Static-type value bytes give two symbols each.
// Reset (arst_n low) returns the parser to the type high byte and empties all beats.
// ----------------------------------------------------------------------------
// tls_extension_fingerprinter_unit
// TLS extension list fingerprinter: turns extension vector bytes into open,
// hex digit, close and discard symbols.
// ----------------------------------------------------------------------------
module tls_extension_fingerprinter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tef_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tef_pkg::out_beat_t  out_data
);

	// Input beats are parsed in the cycle they are accepted; parser state
	// advances at that edge and the beat's whole symbol group is registered
	// in the emitter. A new beat is taken whenever the group register is
	// empty or its last symbol moves to the output register this cycle,
	// so bytes that cause no symbol, or one, flow at a beat per cycle while the output is not stalled.

	logic                 take;
	logic                 grp_free;
	tef_pkg::sym_group_t  group;

	assign in_ready = grp_free;
	assign take     = in_valid && in_ready;

	tef_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.beat   (in_data),
		.group  (group)
	);

	// serializer: group register plus output register
	tef_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.group     (group),
		.free      (grp_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: verif/tls_extension_fingerprinter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_extension_fingerprinter_unit_tb
// Self-checking bench for the extension fingerprinter. Extension vector bytes
// are sent as input beats. A byte-level predictor works out the symbols that
// each byte should cause. A checker compares every output beat, in order,
// against those symbols. Runs cover directed corner cases, random well-formed
// and truncated vectors, noise bytes, idle and stall mixes, and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tls_extension_fingerprinter_unit_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_TAIL  = 20;
	localparam int HOLD_CYCLES = 300;

	// types whose length and value bytes are printed
	localparam int NUM_FP_STATIC = 34;
	localparam logic [15:0] FP_STATIC_TYPES [NUM_FP_STATIC] = '{
		16'h0001, 16'h0005, 16'h0007, 16'h0008, 16'h0009, 16'h000a, 16'h000b,
		16'h000d, 16'h000f, 16'h0010, 16'h0011, 16'h0018, 16'h001b, 16'h001c,
		16'h002b, 16'h002d, 16'h0032, 16'h0a0a, 16'h1a1a, 16'h2a2a, 16'h3a3a,
		16'h4a4a, 16'h5500, 16'h5a5a, 16'h6a6a, 16'h7a7a, 16'h8a8a, 16'h9a9a,
		16'haaaa, 16'hbaba, 16'hcaca, 16'hdada, 16'heaea, 16'hfafa
	};

	typedef enum logic [2:0] {
		PH_TYPE_HI,
		PH_TYPE_LO,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_VALUE
	} parse_phase_e;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	tef_pkg::in_beat_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	tef_pkg::out_beat_t out_data;

	// predictor state
	parse_phase_e fp_phase = PH_TYPE_HI;
	logic [7:0]   fp_type_hi = '0;
	logic [15:0]  fp_bytes_left = '0;
	logic         fp_static = 1'b0;

	tef_pkg::out_beat_t byte_syms[$];     // symbols of the byte being predicted
	tef_pkg::out_beat_t expected_syms[$]; // symbols still due on the output
	logic [7:0]         vec_bytes[$];     // vector under construction

	int mismatch_count = 0;
	int beats_sent     = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// hold-off: the test bumps the request, the receiver owns the countdown
	int hold_off_req  = 0;
	int hold_off_seen = 0;
	int hold_off_left = 0;

	tls_extension_fingerprinter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic logic fp_is_static(input logic [15:0] t);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_FP_STATIC; i++) begin
			if (FP_STATIC_TYPES[i] == t) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic void add_sym(input logic [1:0] kind, input logic [3:0] digit);
		byte_syms.push_back(tef_pkg::out_beat_t'{symbol_kind: kind, hex_digit: digit,
			run_last: 1'b0});
	endfunction

	function automatic void add_hex_byte(input logic [7:0] b);
		add_sym(tef_pkg::KIND_HEX, b[7:4]);
		add_sym(tef_pkg::KIND_HEX, b[3:0]);
	endfunction

	// Advance the predictor by one input byte and queue the symbols it causes.
	function automatic void fingerprint_byte(input logic [7:0] b, input logic last);
		logic [15:0] shown;
		logic        closed;
		closed = 1'b0;
		case (fp_phase)
			PH_TYPE_LO: begin
				// a vector that ends inside the type prints nothing
				if (!last) begin
					shown = {fp_type_hi, b};
					fp_static = fp_is_static(shown);
					// GREASE: both bytes equal with low nibble a
					if (fp_type_hi == b && b[3:0] == 4'ha) begin
						shown = tef_pkg::GREASE_OUT;
					end
					add_sym(tef_pkg::KIND_OPEN, 4'h0);
					add_sym(tef_pkg::KIND_HEX, shown[15:12]);
					add_sym(tef_pkg::KIND_HEX, shown[11:8]);
					add_sym(tef_pkg::KIND_HEX, shown[7:4]);
					add_sym(tef_pkg::KIND_HEX, shown[3:0]);
					fp_phase = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				fp_bytes_left = {b, 8'h00};
				if (last) begin
					add_sym(tef_pkg::KIND_DISCARD, 4'h0);
				end else begin
					if (fp_static) begin
						add_hex_byte(b);
					end
					fp_phase = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				fp_bytes_left = fp_bytes_left | {8'h00, b};
				if (fp_bytes_left == 16'd0) begin
					if (fp_static) begin
						add_hex_byte(b);
					end
					add_sym(tef_pkg::KIND_CLOSE, 4'h0);
					closed = 1'b1;
				end else if (last) begin
					add_sym(tef_pkg::KIND_DISCARD, 4'h0);
				end else begin
					if (fp_static) begin
						add_hex_byte(b);
					end
					fp_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				fp_bytes_left = fp_bytes_left - 16'd1;
				if (fp_bytes_left == 16'd0) begin
					if (fp_static) begin
						add_hex_byte(b);
					end
					add_sym(tef_pkg::KIND_CLOSE, 4'h0);
					closed = 1'b1;
				end else if (last) begin
					add_sym(tef_pkg::KIND_DISCARD, 4'h0);
				end else if (fp_static) begin
					add_hex_byte(b);
				end
			end
			default: begin
				fp_type_hi = b;
				fp_phase = PH_TYPE_LO;
			end
		endcase
		if (closed || last) begin
			fp_phase = PH_TYPE_HI;
			fp_bytes_left = '0;
			fp_static = 1'b0;
		end
		if (last) begin
			fp_type_hi = '0;
		end
		if (byte_syms.size() != 0) begin
			byte_syms[byte_syms.size() - 1].run_last = 1'b1;
		end
		foreach (byte_syms[i]) begin
			expected_syms.push_back(byte_syms[i]);
		end
		byte_syms.delete();
	endfunction

	// ------------------------------------------------------------------------
	// Output side: check accepted beats, then pick out_ready for the next edge
	// ------------------------------------------------------------------------
	task automatic check_symbol(input tef_pkg::out_beat_t got);
		tef_pkg::out_beat_t want;
		if (expected_syms.size() == 0) begin
			$display("%0t ns: unexpected symbol: expected none, actual %0d/%h/%b",
				$time, got.symbol_kind, got.hex_digit, got.run_last);
			mismatch_count++;
		end else begin
			want = expected_syms.pop_front();
			if (got !== want) begin
				$display("%0t ns: mismatch: expected %0d/%h/%b, actual %0d/%h/%b",
					$time, want.symbol_kind, want.hex_digit, want.run_last,
					got.symbol_kind, got.hex_digit, got.run_last);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			check_symbol(out_data);
		end
		if (hold_off_req != hold_off_seen) begin
			hold_off_seen = hold_off_req;
			hold_off_left = HOLD_CYCLES;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------
	// Called at a rising edge; returns at the edge where the beat was taken.
	// Valid stays high into the next beat unless an idle gap is drawn.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		fingerprint_byte(b, last);
		in_valid <= 1'b1;
		in_data  <= tef_pkg::in_beat_t'{data_byte: b, vector_end: last};
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic send_vec_bytes(input logic end_on_last);
		for (int i = 0; i < vec_bytes.size(); i++) begin
			send_byte(vec_bytes[i], end_on_last && (i == vec_bytes.size() - 1));
		end
		vec_bytes.delete();
	endtask

	// Appends the first count bytes of one extension: type, length, then values.
	function automatic void append_extension(input logic [15:0] t, input logic [15:0] len,
			input int count);
		logic [7:0] hdr[4];
		hdr = '{t[15:8], t[7:0], len[15:8], len[7:0]};
		for (int i = 0; i < count; i++) begin
			vec_bytes.push_back((i < 4) ? hdr[i] : 8'($urandom_range(255)));
		end
	endfunction

	function automatic logic [15:0] pick_type();
		int         r;
		logic [3:0] n;
		r = $urandom_range(99);
		n = 4'($urandom_range(15));
		if (r < 40) begin
			return FP_STATIC_TYPES[$urandom_range(NUM_FP_STATIC - 1)];
		end else if (r < 55) begin
			return {n, 4'ha, n, 4'ha};
		end
		return 16'($urandom_range(16'hffff));
	endfunction

	// Mostly short extensions keep the run fast; a few longer ones.
	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 15) begin
			return 16'd0;
		end else if (r < 60) begin
			return 16'($urandom_range(1, 4));
		end else if (r < 90) begin
			return 16'($urandom_range(5, 16));
		end
		return 16'($urandom_range(17, 48));
	endfunction

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (expected_syms.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// zero type with zero length, GREASE fafa, non-static ffff, then the
		// vector ends on a length high byte
		vec_bytes = '{8'h00, 8'h00, 8'h00, 8'h00,
			8'hfa, 8'hfa, 8'h00, 8'h01, 8'hff,
			8'hff, 8'hff, 8'h00, 8'h01, 8'h5a,
			8'h00, 8'h32, 8'h01};
		send_vec_bytes(1'b1);
		// vector ends inside the value of a static type
		vec_bytes = '{8'h55, 8'h00, 8'h00, 8'h02, 8'h81};
		send_vec_bytes(1'b1);
		// vector ends on a type high byte, then on a type low byte
		vec_bytes = '{8'h7f};
		send_vec_bytes(1'b1);
		vec_bytes = '{8'h00, 8'h2b};
		send_vec_bytes(1'b1);
		// vector ends exactly on a zero-length extension's close
		vec_bytes = '{8'h00, 8'h0a, 8'h00, 8'h00};
		send_vec_bytes(1'b1);
		wait_until_drained();
	endtask

	task automatic test_random_vectors(input int beats, input int idle_pct, input int stall_pct);
		int          stop_at;
		int          n_ext;
		int          cut;
		logic        truncated;
		logic [15:0] len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			if ($urandom_range(9) == 0) begin
				// noise: loose bytes that may land in any parser phase
				repeat ($urandom_range(1, 3)) begin
					send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
				end
			end else begin
				truncated = ($urandom_range(3) == 0);
				n_ext = truncated ? $urandom_range(0, 2) : $urandom_range(1, 4);
				for (int i = 0; i < n_ext; i++) begin
					len = pick_len();
					append_extension(pick_type(), len, 4 + len);
				end
				if (truncated) begin
					// full-range length is fine here: the vector stops early
					len = $urandom_range(1) ? pick_len() : 16'($urandom_range(16'hffff));
					cut = (len > 16'd8) ? 12 : 4 + len;
					append_extension(pick_type(), len, $urandom_range(1, cut - 1));
				end
				send_vec_bytes(1'b1);
			end
		end
		wait_until_drained();
	endtask

	// Receiver holds off while the sender streams a long static extension,
	// so the block backs up and drops in_ready.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_req++;
		append_extension(16'h0010, 16'd40, 44);
		send_vec_bytes(1'b1);
		wait_until_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_vectors(85, 0, 0);
		test_random_vectors(85, 85, 0);
		test_random_vectors(85, 0, 85);
		test_random_vectors(85, 13, 13);
		test_backpressure();

		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0 && expected_syms.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
